/* hdl/tsr_pkg.sv */
package tsr_pkg;

    localparam int MAX_TILE_SIZE   = 4096;
    localparam int MAX_SAMPLE_STEP = 256;

    // field widths
    localparam int INDEX_W = 16;
    localparam int TILE_W  = 13;
    localparam int STEP_W  = 9;
    localparam int LIM_W   = 24;
    localparam int SAMP_W  = 29;
    localparam int START_W = 28;

    localparam int IN_BITS  = INDEX_W + TILE_W + STEP_W + 2 * LIM_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * TILE_W + 2 * SAMP_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TILE_W-1:0] TILE_FIELD_MAX = {TILE_W{1'b1}};

    // pipelined restoring divider: DIV_BITS quotient bits per stage
    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;
    localparam int REM_W      = $clog2(MAX_SAMPLE_STEP);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] word;   // dividend shifts out at the top, quotient in at the bottom
    } div_t;

    typedef struct packed {
        logic              after_lo;
        logic              end_pos;
        logic [TILE_W-1:0] ein;
        logic [TILE_W-1:0] bin_lo;
        logic              empty_lo;
        logic [STEP_W-1:0] step;
    } side_t;

    function automatic div_t div_step(input div_t d, input logic [STEP_W-1:0] step);
        div_t           o;
        logic [REM_W:0] r;
        o = d;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r      = {o.rem, o.word[DIV_W-1]};
            o.word = {o.word[DIV_W-2:0], 1'b0};
            if (r >= step)
            begin
                r         = r - step;
                o.word[0] = 1'b1;
            end
            o.rem = r[REM_W-1:0];
        end
        return o;
    endfunction

endpackage

/* hdl/tile_subsample_range.sv */
// pipeline: 12 register stages
// stages: input, tile start multiply, offsets, eight divider stages of 4 quotient bits, output
// throughput: one word per cycle while the output is not stalled; the two 32-bit dividers are fully pipelined
// each stage holds its word while the next one is full and cannot advance, so bubbles close up under stalls
// reset: rst_n low clears all stage valid bits at once; no clearing pass is needed
module tile_subsample_range
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tile_index, tile_size, sample_step, low_limit, high_limit, zero fill
    input  logic [tsr_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // begin_in_tile, end_in_tile, first_sampled, end_sampled, tile_empty, zero fill
    output logic [tsr_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int NSTAGE = tsr_pkg::DIV_STAGES + 4;
    localparam int DIV0   = 3;
    localparam int LAST   = NSTAGE - 1;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    // stage 1: inputs with saturation
    logic [tsr_pkg::INDEX_W-1:0] idx1_reg;
    logic [tsr_pkg::TILE_W-1:0]  size1_reg, size2_reg;
    logic [tsr_pkg::STEP_W-1:0]  step1_reg, step2_reg;
    logic [tsr_pkg::LIM_W-1:0]   lo1_reg, lo2_reg, hi1_reg, hi2_reg;
    logic [tsr_pkg::TILE_W-1:0]  size_next;
    logic [tsr_pkg::STEP_W-1:0]  step_next;
    logic [tsr_pkg::TILE_W-1:0]  in_size;
    logic [tsr_pkg::STEP_W-1:0]  in_step;

    // stage 2: tile start
    logic [tsr_pkg::START_W-1:0] start2_reg;

    // stage 3: dividends and side info
    tsr_pkg::div_t  first3_reg, end3_reg, first3_next, end3_next;
    tsr_pkg::side_t side3_reg, side3_next;

    // divider stages
    tsr_pkg::div_t  dfirst_reg [tsr_pkg::DIV_STAGES];
    tsr_pkg::div_t  dend_reg   [tsr_pkg::DIV_STAGES];
    tsr_pkg::side_t dside_reg  [tsr_pkg::DIV_STAGES];

    // output register
    logic [tsr_pkg::TILE_W-1:0] bin_reg, ein_reg, bin_next;
    logic [tsr_pkg::SAMP_W-1:0] first_reg, endc_reg, first_next, endc_next;
    logic                       empty_reg, empty_next;

    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1
    assign in_size = s_axis_tdata[tsr_pkg::INDEX_W +: tsr_pkg::TILE_W];
    assign in_step = s_axis_tdata[tsr_pkg::INDEX_W + tsr_pkg::TILE_W +: tsr_pkg::STEP_W];

    always_comb
    begin
        if (in_size > tsr_pkg::TILE_W'(tsr_pkg::MAX_TILE_SIZE))
        begin
            size_next = tsr_pkg::TILE_W'(tsr_pkg::MAX_TILE_SIZE);
        end
        else
        begin
            size_next = in_size;
        end
        if (in_step > tsr_pkg::STEP_W'(tsr_pkg::MAX_SAMPLE_STEP))
        begin
            step_next = tsr_pkg::STEP_W'(tsr_pkg::MAX_SAMPLE_STEP);
        end
        else if (in_step == '0)
        begin
            step_next = tsr_pkg::STEP_W'(1);
        end
        else
        begin
            step_next = in_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            idx1_reg  <= s_axis_tdata[tsr_pkg::INDEX_W-1:0];
            size1_reg <= size_next;
            step1_reg <= step_next;
            lo1_reg   <= s_axis_tdata[tsr_pkg::INDEX_W + tsr_pkg::TILE_W + tsr_pkg::STEP_W
                                      +: tsr_pkg::LIM_W];
            hi1_reg   <= s_axis_tdata[tsr_pkg::INDEX_W + tsr_pkg::TILE_W + tsr_pkg::STEP_W
                                      + tsr_pkg::LIM_W +: tsr_pkg::LIM_W];
        end
    end

    // stage 2: start = index * size
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            start2_reg <= tsr_pkg::START_W'(idx1_reg) * tsr_pkg::START_W'(size1_reg);
            size2_reg  <= size1_reg;
            step2_reg  <= step1_reg;
            lo2_reg    <= lo1_reg;
            hi2_reg    <= hi1_reg;
        end
    end

    // stage 3: offsets from the low limit, clipped end, ceiling dividends
    always_comb
    begin
        logic [tsr_pkg::SAMP_W-1:0] stop_w;
        logic [tsr_pkg::LIM_W-1:0]  bin_lo_w;
        stop_w                = tsr_pkg::SAMP_W'(start2_reg) + tsr_pkg::SAMP_W'(size2_reg);
        side3_next.after_lo   = start2_reg > tsr_pkg::START_W'(lo2_reg);
        side3_next.end_pos    = stop_w > tsr_pkg::SAMP_W'(lo2_reg);
        side3_next.step       = step2_reg;

        first3_next.rem  = '0;
        first3_next.word = tsr_pkg::DIV_W'(start2_reg - tsr_pkg::START_W'(lo2_reg))
                           + tsr_pkg::DIV_W'(step2_reg) - tsr_pkg::DIV_W'(1);
        end3_next.rem    = '0;
        end3_next.word   = tsr_pkg::DIV_W'(stop_w - tsr_pkg::SAMP_W'(lo2_reg))
                           + tsr_pkg::DIV_W'(step2_reg) - tsr_pkg::DIV_W'(1);

        if (stop_w <= tsr_pkg::SAMP_W'(hi2_reg))
        begin
            side3_next.ein = size2_reg;
        end
        else if (start2_reg <= tsr_pkg::START_W'(hi2_reg))
        begin
            side3_next.ein = tsr_pkg::TILE_W'(tsr_pkg::START_W'(hi2_reg) - start2_reg);
        end
        else
        begin
            side3_next.ein = '0;
        end

        // tile starting at or before the low limit
        bin_lo_w            = lo2_reg - tsr_pkg::LIM_W'(start2_reg);
        side3_next.empty_lo = tsr_pkg::LIM_W'(side3_next.ein) <= bin_lo_w;
        if (bin_lo_w > tsr_pkg::LIM_W'(tsr_pkg::TILE_FIELD_MAX))
        begin
            side3_next.bin_lo = tsr_pkg::TILE_FIELD_MAX;
        end
        else
        begin
            side3_next.bin_lo = tsr_pkg::TILE_W'(bin_lo_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            first3_reg <= first3_next;
            end3_reg   <= end3_next;
            side3_reg  <= side3_next;
        end
    end

    // divider stages
    for (genvar g = 0; g < tsr_pkg::DIV_STAGES; g++)
    begin : g_div
        tsr_pkg::div_t  fin, ein_d;
        tsr_pkg::side_t sin;
        if (g == 0)
        begin : g_head
            assign fin   = first3_reg;
            assign ein_d = end3_reg;
            assign sin   = side3_reg;
        end
        else
        begin : g_body
            assign fin   = dfirst_reg[g-1];
            assign ein_d = dend_reg[g-1];
            assign sin   = dside_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv[DIV0 + g])
            begin
                dfirst_reg[g] <= tsr_pkg::div_step(fin, sin.step);
                dend_reg[g]   <= tsr_pkg::div_step(ein_d, sin.step);
                dside_reg[g]  <= sin;
            end
        end
    end

    // final: grid offset from the remainder, select by case
    always_comb
    begin
        tsr_pkg::div_t  qf;
        tsr_pkg::div_t  qe;
        tsr_pkg::side_t sd;
        logic [tsr_pkg::TILE_W-1:0] bin_grid;
        qf = dfirst_reg[tsr_pkg::DIV_STAGES-1];
        qe = dend_reg[tsr_pkg::DIV_STAGES-1];
        sd = dside_reg[tsr_pkg::DIV_STAGES-1];
        // cnt*step - off == step - 1 - remainder
        bin_grid = tsr_pkg::TILE_W'(sd.step - tsr_pkg::STEP_W'(1)
                                    - tsr_pkg::STEP_W'(qf.rem));
        if (sd.after_lo)
        begin
            bin_next   = bin_grid;
            first_next = qf.word[tsr_pkg::SAMP_W-1:0];
            empty_next = sd.ein <= bin_grid;
        end
        else
        begin
            bin_next   = sd.bin_lo;
            first_next = '0;
            empty_next = sd.empty_lo;
        end
        if (sd.end_pos)
        begin
            endc_next = qe.word[tsr_pkg::SAMP_W-1:0];
        end
        else
        begin
            endc_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            bin_reg   <= bin_next;
            ein_reg   <= dside_reg[tsr_pkg::DIV_STAGES-1].ein;
            first_reg <= first_next;
            endc_reg  <= endc_next;
            empty_reg <= empty_next;
        end
    end

    assign m_axis_tdata = tsr_pkg::OUT_W'({empty_reg, endc_reg, first_reg, ein_reg, bin_reg});

endmodule

/* tb/sv/tb.sv */
typedef struct packed {
    logic [tsr_pkg::LIM_W-1:0]   high_limit;
    logic [tsr_pkg::LIM_W-1:0]   low_limit;
    logic [tsr_pkg::STEP_W-1:0]  sample_step;
    logic [tsr_pkg::TILE_W-1:0]  tile_size;
    logic [tsr_pkg::INDEX_W-1:0] tile_index;
} tile_query_t;

typedef struct packed {
    logic                       tile_empty;
    logic [tsr_pkg::SAMP_W-1:0] end_sampled;
    logic [tsr_pkg::SAMP_W-1:0] first_sampled;
    logic [tsr_pkg::TILE_W-1:0] end_in_tile;
    logic [tsr_pkg::TILE_W-1:0] begin_in_tile;
} tile_range_t;

class tile_range_board;
    tile_range_t expected_q[$];
    int          fails;
    int          checked;
    int          empties;
    int          saturated;

    function tile_range_t compute_tile_range(tile_query_t q);
        tile_range_t    r;
        longint unsigned idx, size, step, lo, hi;
        longint unsigned start, stop, off, cnt, bin, ein, first, endc;
        bit              empty;
        idx  = q.tile_index;
        size = q.tile_size;
        step = q.sample_step;
        lo   = q.low_limit;
        hi   = q.high_limit;
        if (size > tsr_pkg::MAX_TILE_SIZE)
            size = tsr_pkg::MAX_TILE_SIZE;
        if (step > tsr_pkg::MAX_SAMPLE_STEP)
            step = tsr_pkg::MAX_SAMPLE_STEP;
        if (step == 0)
            step = 1;
        start = idx * size;
        stop  = (idx + 1) * size;
        if (start > lo)
        begin
            off   = start - lo;
            cnt   = (off + step - 1) / step;
            bin   = cnt * step - off;
            first = cnt;
        end
        else
        begin
            bin   = lo - start;
            first = 0;
        end
        if (stop <= hi)
            ein = size;
        else if (start <= hi)
            ein = hi - start;
        else
            ein = 0;
        endc  = (stop > lo) ? (stop - lo + step - 1) / step : 0;
        // flag is decided before the offsets saturate
        empty = (ein <= bin);
        if (bin > 8191)
            bin = 8191;
        if (ein > 8191)
            ein = 8191;
        if (first > 64'h1FFF_FFFF)
            first = 64'h1FFF_FFFF;
        if (endc > 64'h1FFF_FFFF)
            endc = 64'h1FFF_FFFF;
        r.begin_in_tile = bin[tsr_pkg::TILE_W-1:0];
        r.end_in_tile   = ein[tsr_pkg::TILE_W-1:0];
        r.first_sampled = first[tsr_pkg::SAMP_W-1:0];
        r.end_sampled   = endc[tsr_pkg::SAMP_W-1:0];
        r.tile_empty    = empty;
        return r;
    endfunction

    function void note_tile(logic [tsr_pkg::IN_W-1:0] w);
        tile_range_t r;
        r = compute_tile_range(tile_query_t'(w[tsr_pkg::IN_BITS-1:0]));
        if (r.tile_empty)
            empties++;
        if (r.begin_in_tile == tsr_pkg::TILE_FIELD_MAX)
            saturated++;
        expected_q.push_back(r);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        fails++;
        if (fails <= 100)
            $display("mismatch at word %0d, %s: got %0d expected %0d", checked, what, got, want);
    endtask

    task check_result(logic [tsr_pkg::OUT_W-1:0] w);
        tile_range_t got, want;
        got = tile_range_t'(w[tsr_pkg::OUT_BITS-1:0]);
        if (expected_q.size() == 0)
        begin
            report_mismatch("words pending", 1, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.begin_in_tile !== want.begin_in_tile)
            report_mismatch("begin_in_tile", got.begin_in_tile, want.begin_in_tile);
        if (got.end_in_tile !== want.end_in_tile)
            report_mismatch("end_in_tile", got.end_in_tile, want.end_in_tile);
        if (got.first_sampled !== want.first_sampled)
            report_mismatch("first_sampled", got.first_sampled, want.first_sampled);
        if (got.end_sampled !== want.end_sampled)
            report_mismatch("end_sampled", got.end_sampled, want.end_sampled);
        if (got.tile_empty !== want.tile_empty)
            report_mismatch("tile_empty", got.tile_empty, want.tile_empty);
        checked++;
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1800;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [tsr_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [tsr_pkg::OUT_W-1:0] m_axis_tdata;

    tile_range_board board;
    bit              calm;
    int              idle_cycles;

    tile_subsample_range DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic tile_query_t make_query(int unsigned idx, int unsigned size,
                                               int unsigned step, int unsigned lo,
                                               int unsigned hi);
        tile_query_t q;
        q.tile_index  = idx[tsr_pkg::INDEX_W-1:0];
        q.tile_size   = size[tsr_pkg::TILE_W-1:0];
        q.sample_step = step[tsr_pkg::STEP_W-1:0];
        q.low_limit   = lo[tsr_pkg::LIM_W-1:0];
        q.high_limit  = hi[tsr_pkg::LIM_W-1:0];
        return q;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_tile(tile_query_t q);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {{(tsr_pkg::IN_W - tsr_pkg::IN_BITS){1'b0}}, q};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_tile(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        tile_query_t q;
        int unsigned size, step, span, lo, hi, anchor;
        int          pos;
        board         = new();
        calm          = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero size and zero step
        send_tile(make_query(0, 0, 0, 0, 0));
        send_tile(make_query(5, 100, 0, 30, 2000));
        // every field at its top, oversized size and step saturate
        send_tile(make_query(65535, 8191, 511, 24'hFFFFFF, 24'hFFFFFF));
        send_tile(make_query(7, 5000, 300, 1000, 40000));
        send_tile(make_query(65535, 4096, 256, 0, 24'hFFFFFF));
        send_tile(make_query(4095, 4096, 256, 12345, 24'hFFFFFF));
        // tile starting before the low limit, begin offset saturated far below
        send_tile(make_query(0, 100, 7, 50, 1000));
        send_tile(make_query(0, 4096, 3, 24'hFFFFFF, 24'hFFFFFF));
        send_tile(make_query(2, 100, 9, 200, 1000));
        // tile beyond the high limit
        send_tile(make_query(10, 100, 4, 0, 500));
        send_tile(make_query(4, 100, 4, 0, 400));
        send_tile(make_query(3, 100, 4, 0, 400));
        send_tile(make_query(3, 100, 4, 0, 300));
        send_tile(make_query(3, 100, 4, 0, 350));
        // tile end not above the low limit
        send_tile(make_query(1, 100, 5, 250, 1000));
        send_tile(make_query(1, 100, 5, 200, 1000));
        // end offset past the start but below the grid point
        send_tile(make_query(1, 100, 64, 3, 105));
        send_tile(make_query(1, 1, 1, 0, 24'hFFFFFF));
        send_tile(make_query(16'hAAAA, 13'h0AAA, 9'h0AA, 24'h555555, 24'hAAAAAA));
        send_tile(make_query(16'h5555, 13'h1555, 9'h155, 24'hAAAAAA, 24'h555555));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i / 300) % 3 == 1);
            if ($urandom_range(0, 4) == 0)
            begin
                q = make_query($urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                // tiles placed around the low or the high limit
                size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                   : $urandom_range(1, 64);
                step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                   : $urandom_range(1, 12);
                if ($urandom_range(0, 31) == 0)
                    step = 0;
                span = size * $urandom_range(1, 3000);
                lo   = $urandom_range(0, span);
                if ($urandom_range(0, 5) == 0)
                    hi = $urandom_range(0, span);
                else
                    hi = lo + $urandom_range(0, span);
                if (hi > 24'hFFFFFF)
                    hi = 24'hFFFFFF;
                anchor = $urandom_range(0, 1) ? lo : hi;
                pos = int'(anchor / size) + int'($urandom_range(0, 4)) - 2;
                if (pos < 0)
                    pos = 0;
                if (pos > 65535)
                    pos = 65535;
                q = make_query(pos, size, step, lo, hi);
            end
            send_tile(q);
            if (i == RANDOM_ITEMS / 2)
            begin
                // let the pipeline drain completely once
                s_axis_tvalid <= 1'b0;
                while (board.pending() != 0)
                    @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("summary: %0d queries checked, %0d empty, %0d begin offsets saturated",
                 board.checked, board.empties, board.saturated);
        $display("summary: limits around tile edges, zero and oversized size and step, stalls");
        if (board.fails == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
